FILE: rtl/core/bfr_pkg.sv
package bfr_pkg;

  // defaults for the module parameters
  localparam int unsigned CellWidthDef = 8;
  localparam int unsigned LinePitchDef = 10;
  localparam int unsigned CoordBitsDef = 12;
  localparam int unsigned QueueDepthDef = 2;

  // fixed glyph geometry
  localparam int unsigned GlyphRows = 8;
  localparam int unsigned GlyphCols = 8;
  localparam int unsigned GlyphIdxW = $clog2(GlyphRows * GlyphCols);
  localparam int unsigned RowW = $clog2(GlyphRows);
  localparam int unsigned ColW = $clog2(GlyphCols);

  localparam int unsigned CodeW = 8;
  localparam int unsigned ColorW = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam logic [ColorW-1:0] InkColorRst = 16'hFFFF;

  // character codes
  localparam logic [CodeW-1:0] ChNewline = 8'd10;
  localparam logic [CodeW-1:0] ChBang = 8'd33;
  localparam logic [CodeW-1:0] ChDot = 8'd46;
  localparam logic [CodeW-1:0] ChDigit0 = 8'd48;
  localparam logic [CodeW-1:0] ChDigit9 = 8'd57;
  localparam logic [CodeW-1:0] ChUpperA = 8'd65;
  localparam logic [CodeW-1:0] ChUpperB = 8'd66;
  localparam logic [CodeW-1:0] ChUpperC = 8'd67;
  localparam logic [CodeW-1:0] ChUpperZ = 8'd90;
  localparam logic [CodeW-1:0] ChLowerA = 8'd97;
  localparam logic [CodeW-1:0] ChLowerZ = 8'd122;
  localparam logic [CodeW-1:0] ChCaseOfs = 8'd32;
  localparam logic [CodeW-1:0] ChFirstHigh = 8'd128;

  // glyph row patterns, bits 15..8 are columns 0..7
  localparam logic [15:0] RowEmpty = 16'h0000;
  localparam logic [15:0] RowStem = 16'h0100;
  localparam logic [15:0] RowCap = 16'h0380;
  localparam logic [15:0] RowSides = 16'h0440;
  localparam logic [15:0] RowBar = 16'h07C0;
  localparam logic [15:0] RowBump = 16'h0780;
  localparam logic [15:0] RowLeft = 16'h0040;

  typedef enum logic [2:0] {
    SHAPE_BLANK,
    SHAPE_BANG,
    SHAPE_DOT,
    SHAPE_DIGIT,
    SHAPE_A,
    SHAPE_B,
    SHAPE_OTHER
  } shape_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ORIGIN_X = 2'd0,
    CFG_ORIGIN_Y = 2'd1,
    CFG_INK_COLOR = 2'd2
  } cfg_reg_e;

  // scan index (row * 8 + column) of the last set pixel of each shape
  localparam logic [GlyphIdxW-1:0] LastIdxA = 6'd53;
  localparam logic [GlyphIdxW-1:0] LastIdxStd = 6'd55;

  function automatic logic [15:0] glyph_row(shape_e s, logic [RowW-1:0] r);
    logic [15:0] v;
    v = RowEmpty;
    case (s)
      SHAPE_BANG: begin
        v = (r == 3'd5 || r == 3'd7) ? RowEmpty : RowStem;
      end
      SHAPE_DOT: begin
        v = (r == 3'd6) ? RowStem : RowEmpty;
      end
      SHAPE_DIGIT: begin
        case (r)
          3'd0, 3'd6: v = RowCap;
          3'd7: v = RowEmpty;
          default: v = RowSides;
        endcase
      end
      SHAPE_A: begin
        case (r)
          3'd0: v = RowCap;
          3'd3: v = RowBar;
          3'd7: v = RowEmpty;
          default: v = RowSides;
        endcase
      end
      SHAPE_B: begin
        case (r)
          3'd0, 3'd3, 3'd6: v = RowBump;
          3'd7: v = RowEmpty;
          default: v = RowSides;
        endcase
      end
      SHAPE_OTHER: begin
        case (r)
          3'd0, 3'd6: v = RowCap;
          3'd1, 3'd5: v = RowSides;
          3'd7: v = RowEmpty;
          default: v = RowLeft;
        endcase
      end
      default: v = RowEmpty;
    endcase
    return v;
  endfunction

  function automatic logic [GlyphIdxW-1:0] glyph_last(shape_e s);
    logic [GlyphIdxW-1:0] v;
    v = LastIdxStd;
    case (s)
      SHAPE_A: v = LastIdxA;
      default: v = LastIdxStd;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/bitmap_font_text_renderer_core.sv
// 8x8 bitmap text renderer. Each request carries one character byte; the
// block keeps a text cursor and emits one pixel write per set glyph pixel in
// raster order, flagging the final write of the character with last_pixel_o.
// Newline, blank glyphs and codes 128 to 255 draw nothing and only move the
// cursor. The front end classifies a character and updates the cursor in
// the cycle it is taken, as long as the two-entry queue has room; printable
// characters queue up for the back end, which walks the glyph positions in
// raster order at one position per cycle, held off while the output slot is
// full, up to the last set pixel (position 55, or 53 for the letter A), while
// newlines and blank characters are handled in the front end alone.
// Coordinates saturate at the top of the coordinate range.
module bitmap_font_text_renderer_core #(
  parameter int unsigned CELL_WIDTH = bfr_pkg::CellWidthDef,
  parameter int unsigned LINE_PITCH = bfr_pkg::LinePitchDef,
  parameter int unsigned COORD_BITS = bfr_pkg::CoordBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bfr_pkg::CodeW-1:0]     char_code_i,
  input  logic                          text_start_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [COORD_BITS-1:0]         pixel_x_o,
  output logic [COORD_BITS-1:0]         pixel_y_o,
  output logic [bfr_pkg::ColorW-1:0]    pixel_color_o,
  output logic                          last_pixel_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bfr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bfr_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned CmdW = 3 + 2 * COORD_BITS + bfr_pkg::ColorW;

  logic push_valid, push_ready, head_valid, pop;
  logic [CmdW-1:0] push_data, head_data;

  bfr_front #(
    .CELL_WIDTH (CELL_WIDTH),
    .LINE_PITCH (LINE_PITCH),
    .COORD_BITS (COORD_BITS),
    .CMD_W      (CmdW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_code_i  (char_code_i),
    .text_start_i (text_start_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  bfr_queue #(
    .DATA_W (CmdW),
    .DEPTH  (bfr_pkg::QueueDepthDef)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .head_valid_o (head_valid),
    .head_data_o  (head_data),
    .pop_i        (pop)
  );

  bfr_back #(
    .COORD_BITS (COORD_BITS),
    .CMD_W      (CmdW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_data_i   (head_data),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .last_pixel_o  (last_pixel_o)
  );

endmodule

FILE: rtl/core/bfr_front.sv
module bfr_front #(
  parameter int unsigned CELL_WIDTH = bfr_pkg::CellWidthDef,
  parameter int unsigned LINE_PITCH = bfr_pkg::LinePitchDef,
  parameter int unsigned COORD_BITS = bfr_pkg::CoordBitsDef,
  parameter int unsigned CMD_W = 3 + 2 * COORD_BITS + bfr_pkg::ColorW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bfr_pkg::CodeW-1:0]     char_code_i,
  input  logic                          text_start_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bfr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bfr_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output logic [CMD_W-1:0]              push_data_o
);

  localparam int unsigned SumW = COORD_BITS + 1;

  logic [COORD_BITS-1:0] origin_x_q, origin_y_q;
  logic [bfr_pkg::ColorW-1:0] ink_q;
  logic [COORD_BITS-1:0] cursor_x_q, cursor_x_d, cursor_y_q, cursor_y_d;
  logic [COORD_BITS-1:0] cx, cy;
  logic [SumW-1:0] sum_x, sum_y;
  logic [bfr_pkg::CodeW-1:0] code;
  bfr_pkg::shape_e shape;
  logic is_newline, accept;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o = push_ready_i;
  assign accept = in_valid_i & push_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      ink_q <= bfr_pkg::InkColorRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bfr_pkg::CFG_ORIGIN_X: origin_x_q <= cfg_data_i[COORD_BITS-1:0];
        bfr_pkg::CFG_ORIGIN_Y: origin_y_q <= cfg_data_i[COORD_BITS-1:0];
        bfr_pkg::CFG_INK_COLOR: ink_q <= cfg_data_i[bfr_pkg::ColorW-1:0];
        default: ink_q <= ink_q;
      endcase
    end
  end

  // fold case and pick the glyph shape
  always_comb begin
    code = char_code_i;
    if (char_code_i >= bfr_pkg::ChLowerA && char_code_i <= bfr_pkg::ChLowerZ) begin
      code = char_code_i - bfr_pkg::ChCaseOfs;
    end
    shape = bfr_pkg::SHAPE_BLANK;
    if (char_code_i >= bfr_pkg::ChFirstHigh) begin
      shape = bfr_pkg::SHAPE_BLANK;
    end else if (code == bfr_pkg::ChBang) begin
      shape = bfr_pkg::SHAPE_BANG;
    end else if (code == bfr_pkg::ChDot) begin
      shape = bfr_pkg::SHAPE_DOT;
    end else if (code >= bfr_pkg::ChDigit0 && code <= bfr_pkg::ChDigit9) begin
      shape = bfr_pkg::SHAPE_DIGIT;
    end else if (code == bfr_pkg::ChUpperA) begin
      shape = bfr_pkg::SHAPE_A;
    end else if (code == bfr_pkg::ChUpperB) begin
      shape = bfr_pkg::SHAPE_B;
    end else if (code >= bfr_pkg::ChUpperC && code <= bfr_pkg::ChUpperZ) begin
      shape = bfr_pkg::SHAPE_OTHER;
    end
  end

  assign is_newline = (char_code_i == bfr_pkg::ChNewline);
  assign cx = text_start_i ? origin_x_q : cursor_x_q;
  assign cy = text_start_i ? origin_y_q : cursor_y_q;
  assign sum_x = {1'b0, cx} + SumW'(CELL_WIDTH);
  assign sum_y = {1'b0, cy} + SumW'(LINE_PITCH);

  always_comb begin
    cursor_x_d = cursor_x_q;
    cursor_y_d = cursor_y_q;
    if (accept) begin
      if (is_newline) begin
        cursor_x_d = origin_x_q;
        cursor_y_d = sum_y[COORD_BITS] ? '1 : sum_y[COORD_BITS-1:0];
      end else begin
        cursor_x_d = sum_x[COORD_BITS] ? '1 : sum_x[COORD_BITS-1:0];
        cursor_y_d = cy;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q <= '0;
      cursor_y_q <= '0;
    end else begin
      cursor_x_q <= cursor_x_d;
      cursor_y_q <= cursor_y_d;
    end
  end

  // blank glyphs and newlines leave nothing for the back end
  assign push_valid_o = in_valid_i & ~is_newline & (shape != bfr_pkg::SHAPE_BLANK);
  assign push_data_o = {shape, cx, cy, ink_q};

endmodule

FILE: rtl/core/bfr_queue.sv
module bfr_queue #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH = bfr_pkg::QueueDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              push_ready_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              head_valid_o,
  output logic [DATA_W-1:0] head_data_o,
  input  logic              pop_i
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_data_o = mem_q[rd_ptr_q];
  assign do_push = push_i & push_ready_o;
  assign do_pop = pop_i & head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/core/bfr_back.sv
module bfr_back #(
  parameter int unsigned COORD_BITS = bfr_pkg::CoordBitsDef,
  parameter int unsigned CMD_W = 3 + 2 * COORD_BITS + bfr_pkg::ColorW
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        head_valid_i,
  input  logic [CMD_W-1:0]            head_data_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [COORD_BITS-1:0]       pixel_x_o,
  output logic [COORD_BITS-1:0]       pixel_y_o,
  output logic [bfr_pkg::ColorW-1:0]  pixel_color_o,
  output logic                        last_pixel_o
);

  localparam int unsigned SumW = COORD_BITS + 1;

  bfr_pkg::shape_e shape;
  logic [COORD_BITS-1:0] base_x, base_y;
  logic [bfr_pkg::ColorW-1:0] color;
  logic [bfr_pkg::GlyphIdxW-1:0] idx_q, idx_d, last_idx;
  logic [bfr_pkg::RowW-1:0] row;
  logic [bfr_pkg::ColW-1:0] col;
  logic [15:0] row_bits;
  logic [7:0] row_hi;
  logic pix_set, step, at_end;
  logic [SumW-1:0] sum_x, sum_y;

  logic out_valid_q, out_valid_d;
  logic [COORD_BITS-1:0] px_q, px_d, py_q, py_d;
  logic [bfr_pkg::ColorW-1:0] pc_q, pc_d;
  logic last_q, last_d;

  assign shape = bfr_pkg::shape_e'(head_data_i[CMD_W-1 -: 3]);
  assign base_x = head_data_i[2*COORD_BITS+bfr_pkg::ColorW-1 -: COORD_BITS];
  assign base_y = head_data_i[COORD_BITS+bfr_pkg::ColorW-1 -: COORD_BITS];
  assign color = head_data_i[bfr_pkg::ColorW-1:0];

  // scan position: row in the upper bits, column in the lower
  assign row = idx_q[bfr_pkg::GlyphIdxW-1 -: bfr_pkg::RowW];
  assign col = idx_q[bfr_pkg::ColW-1:0];
  assign row_bits = bfr_pkg::glyph_row(shape, row);
  assign row_hi = row_bits[15:8];
  assign pix_set = row_hi[3'(3'd7 - col)];
  assign last_idx = bfr_pkg::glyph_last(shape);
  assign at_end = (idx_q == last_idx);

  assign sum_x = {1'b0, base_x} + SumW'(col);
  assign sum_y = {1'b0, base_y} + SumW'(row);

  // one glyph bit per cycle, held off while the output slot is still full
  assign step = head_valid_i & (~out_valid_q | out_ready_i);
  assign pop_o = step & at_end;

  always_comb begin
    idx_d = idx_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    px_d = px_q;
    py_d = py_q;
    pc_d = pc_q;
    last_d = last_q;
    if (step) begin
      idx_d = at_end ? '0 : idx_q + 1'b1;
      if (pix_set) begin
        out_valid_d = 1'b1;
        px_d = sum_x[COORD_BITS] ? '1 : sum_x[COORD_BITS-1:0];
        py_d = sum_y[COORD_BITS] ? '1 : sum_y[COORD_BITS-1:0];
        pc_d = color;
        last_d = at_end;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= px_d;
    py_q <= py_d;
    pc_q <= pc_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign pixel_x_o = px_q;
  assign pixel_y_o = py_q;
  assign pixel_color_o = pc_q;
  assign last_pixel_o = last_q;

endmodule
